/* rtl/lcste_pkg.sv */
// Package for the LCS tile edge solver: transaction structs, opcodes, FSM states.
// No dependencies; used by every module of the block.
`default_nettype none

package lcste_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ROW  = 1'b1;

    localparam logic KIND_RIGHT  = 1'b0;
    localparam logic KIND_BOTTOM = 1'b1;

    localparam int CFG_WIDTH  = 6;
    localparam int OUT_VAL_W  = 16;

    typedef struct packed {
        logic        op;
        logic [4:0]  index;
        logic [7:0]  symbol;
        logic [15:0] edge_value;
        logic [15:0] corner_value;
        logic        first_row;
        logic        last_row;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [4:0]  column;
        logic [15:0] value;
        logic        last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

/* rtl/lcs_tile_edge_solver_core.sv */
// LCS tile edge solver: a row item runs as a token down a chain of column cells.
// Load item: writes one cell's symbol and value. Row item of width n: the right edge is
// registered from cell n-1's done, then busy ends unless a last row adds n bottom-edge results.
// The token walks one cell per cycle, so the tile width sets the item time.
// Results are not back-pressured. Reset clears control, width register (32) and the
// previous left value; cell symbols and values are undefined until loaded.
`default_nettype none

module lcs_tile_edge_solver_core
    import lcste_pkg::*;
#(
    parameter int COLS        = 32,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire in_item_t             item,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_WIDTH-1:0] cfg_data,
    output logic                      result_strobe,
    output out_item_t                 result
);

    localparam int CIW = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int NW  = $clog2(COLS + 1);

    state_t state_reg, state_next;

    logic [CFG_WIDTH-1:0]   cols_reg;
    logic [VALUE_WIDTH-1:0] prev_left_reg;
    logic [7:0]             row_sym_reg;
    logic [VALUE_WIDTH-1:0] inj_left_reg;
    logic [VALUE_WIDTH-1:0] inj_diag_reg;
    logic                   last_row_reg;
    logic                   inject_reg;
    logic [CIW-1:0]         cnt_reg, cnt_next;
    logic                   strobe_reg, strobe_next;
    out_item_t              res_reg, res_next;

    logic                   accept;
    logic                   load_en;
    logic [VALUE_WIDTH-1:0] edge_v;
    logic [VALUE_WIDTH-1:0] corner_v;
    logic [NW-1:0]          n_eff;
    logic [CIW-1:0]         n_m1;
    logic                   any_done;
    logic [VALUE_WIDTH-1:0] right_val;

    logic [COLS-1:0]        tok_fwd;
    logic [COLS-1:0]        done_vec;
    logic [COLS-1:0]        end_sel;
    logic [COLS-1:0]        load_sel;
    logic [VALUE_WIDTH-1:0] left_link [COLS];
    logic [VALUE_WIDTH-1:0] diag_link [COLS];
    logic [VALUE_WIDTH-1:0] cell_val  [COLS];

    assign accept    = start & ~busy;
    assign load_en   = accept & (item.op == OP_LOAD) & (int'(item.index) < COLS);
    assign edge_v    = VALUE_WIDTH'(item.edge_value);
    assign corner_v  = VALUE_WIDTH'(item.corner_value);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // effective tile width: zero acts as one, clamp at COLS
    always_comb
    begin
        if (cols_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(cols_reg) > COLS)
        begin
            n_eff = NW'(COLS);
        end
        else
        begin
            n_eff = NW'(cols_reg);
        end
    end
    assign n_m1 = CIW'(n_eff - 1'b1);

    genvar k;
    generate
        for (k = 0; k < COLS; k++)
        begin : g_cell
            logic                   c_tok;
            logic [VALUE_WIDTH-1:0] c_left;
            logic [VALUE_WIDTH-1:0] c_diag;

            assign end_sel[k]  = (n_m1 == CIW'(k));
            assign load_sel[k] = load_en & (int'(item.index) == k);

            if (k == 0)
            begin : g_head
                assign c_tok  = inject_reg;
                assign c_left = inj_left_reg;
                assign c_diag = inj_diag_reg;
            end
            else
            begin : g_body
                assign c_tok  = tok_fwd[k-1];
                assign c_left = left_link[k-1];
                assign c_diag = diag_link[k-1];
            end

            lcste_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .load_en     (load_sel[k]),
                .load_symbol (item.symbol),
                .load_value  (edge_v),
                .row_symbol  (row_sym_reg),
                .tok_in      (c_tok),
                .left_in     (c_left),
                .diag_in     (c_diag),
                .is_end      (end_sel[k]),
                .tok_fwd     (tok_fwd[k]),
                .done        (done_vec[k]),
                .left_out    (left_link[k]),
                .diag_out    (diag_link[k]),
                .value       (cell_val[k])
            );
        end
    endgenerate

    // at most one cell flags done; pick its left value
    always_comb
    begin
        right_val = '0;
        for (int i = 0; i < COLS; i++)
        begin
            if (done_vec[i])
            begin
                right_val = right_val | left_link[i];
            end
        end
    end
    assign any_done = |done_vec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cols_reg      <= CFG_WIDTH'(32);
            prev_left_reg <= '0;
            inject_reg    <= 1'b0;
            strobe_reg    <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            inject_reg <= accept & (item.op == OP_ROW);
            strobe_reg <= strobe_next;
            cnt_reg    <= cnt_next;
            if (cfg_valid & cfg_ready)
            begin
                cols_reg <= cfg_data;
            end
            if (accept & (item.op == OP_ROW))
            begin
                prev_left_reg <= edge_v;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept & (item.op == OP_ROW))
        begin
            row_sym_reg  <= item.symbol;
            inj_left_reg <= edge_v;
            inj_diag_reg <= item.first_row ? corner_v : prev_left_reg;
            last_row_reg <= item.last_row;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept & (item.op == OP_ROW))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (any_done)
                begin
                    state_next = last_row_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (cnt_reg == n_m1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register and bottom-edge counter
    always_comb
    begin
        strobe_next = 1'b0;
        res_next    = res_reg;
        cnt_next    = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
            end
            ST_RUN:
            begin
                cnt_next = '0;
                if (any_done)
                begin
                    strobe_next     = 1'b1;
                    res_next.kind   = KIND_RIGHT;
                    res_next.column = '0;
                    res_next.value  = OUT_VAL_W'(right_val);
                    res_next.last   = ~last_row_reg;
                end
            end
            ST_EMIT:
            begin
                strobe_next     = 1'b1;
                res_next.kind   = KIND_BOTTOM;
                res_next.column = 5'(cnt_reg);
                res_next.value  = OUT_VAL_W'(cell_val[cnt_reg]);
                res_next.last   = (cnt_reg == n_m1);
                cnt_next        = cnt_reg + 1'b1;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    assign result_strobe = strobe_reg;
    assign result        = res_reg;

endmodule

`default_nettype wire

/* rtl/lcste_cell.sv */
// One column cell of the LCS tile row: holds a column symbol and its table value.
// Depends on lcste_pkg; instantiated in a chain by lcs_tile_edge_solver_core.
`default_nettype none

module lcste_cell
    import lcste_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load_en,
    input  wire logic [7:0]             load_symbol,
    input  wire logic [VALUE_WIDTH-1:0] load_value,
    input  wire logic [7:0]             row_symbol,
    input  wire logic                   tok_in,
    input  wire logic [VALUE_WIDTH-1:0] left_in,
    input  wire logic [VALUE_WIDTH-1:0] diag_in,
    input  wire logic                   is_end,
    output logic                        tok_fwd,
    output logic                        done,
    output logic [VALUE_WIDTH-1:0]      left_out,
    output logic [VALUE_WIDTH-1:0]      diag_out,
    output logic [VALUE_WIDTH-1:0]      value
);

    localparam logic [VALUE_WIDTH-1:0] VMAX = '1;

    logic [7:0]             sym_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic                   tok_reg;
    logic [VALUE_WIDTH-1:0] left_reg;
    logic [VALUE_WIDTH-1:0] diag_reg;
    logic [VALUE_WIDTH-1:0] val_next;

    always_comb
    begin
        if (sym_reg == row_symbol)
        begin
            val_next = (diag_in == VMAX) ? VMAX : diag_in + 1'b1;
        end
        else
        begin
            val_next = (val_reg > left_in) ? val_reg : left_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            sym_reg <= load_symbol;
            val_reg <= load_value;
        end
        else if (tok_in)
        begin
            val_reg <= val_next;
        end
        if (tok_in)
        begin
            left_reg <= val_next;
            diag_reg <= val_reg;   // old value above is the next cell's diagonal
        end
    end

    // the token stops at the last column in use
    assign tok_fwd  = tok_reg & ~is_end;
    assign done     = tok_reg & is_end;
    assign left_out = left_reg;
    assign diag_out = diag_reg;
    assign value    = val_reg;

endmodule

`default_nettype wire
